FILE: rtl/srbm_pkg.sv
`timescale 1ns / 1ps

package srbm_pkg;

	localparam int ByteW = 8;
	localparam int BitIdxW = 3;

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	localparam logic [ByteW-1:0] WRITE_FLAG = 8'h80;
	localparam logic [ByteW-1:0] MIN_LENGTH = 8'd2;

	typedef struct packed {
		logic kind;
		logic [ByteW-1:0] address;
		logic is_write;
		logic [ByteW-1:0] length;
		logic [ByteW-1:0] write_byte;
		logic miso;
	} in_item_t;

	typedef struct packed {
		logic chip_select_n;
		logic mosi;
		logic clock_pulse;
		logic byte_done;
		logic [ByteW-1:0] rx_byte;
		logic burst_last;
	} out_item_t;

endpackage

FILE: rtl/srbm_in_if.sv
`timescale 1ns / 1ps

interface srbm_in_if;
	logic valid;
	logic ready;
	logic kind;
	logic [srbm_pkg::ByteW-1:0] address;
	logic is_write;
	logic [srbm_pkg::ByteW-1:0] length;
	logic [srbm_pkg::ByteW-1:0] write_byte;
	logic miso;

	modport source (output valid, kind, address, is_write, length, write_byte, miso,
		input ready);
	modport sink (input valid, kind, address, is_write, length, write_byte, miso,
		output ready);
endinterface

FILE: rtl/srbm_out_if.sv
`timescale 1ns / 1ps

interface srbm_out_if;
	logic valid;
	logic ready;
	logic chip_select_n;
	logic mosi;
	logic clock_pulse;
	logic byte_done;
	logic [srbm_pkg::ByteW-1:0] rx_byte;
	logic burst_last;

	modport source (output valid, chip_select_n, mosi, clock_pulse, byte_done, rx_byte,
		burst_last, input ready);
	modport sink (input valid, chip_select_n, mosi, clock_pulse, byte_done, rx_byte,
		burst_last, output ready);
endinterface

FILE: rtl/srbm_core.sv
`timescale 1ns / 1ps

module srbm_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  srbm_pkg::in_item_t  item,
	output srbm_pkg::out_item_t result
);
	import srbm_pkg::*;

	logic               busy_q, busy_d;
	logic               write_mode_q, write_mode_d;
	logic               addr_phase_q, addr_phase_d;
	logic [BitIdxW-1:0] bit_idx_q, bit_idx_d;
	logic [ByteW-1:0]   bytes_left_q, bytes_left_d;
	logic [ByteW-1:0]   shift_q, shift_d;
	logic               cs_q, cs_d;
	logic [ByteW-1:0]   tx_src;

	always_comb begin
		busy_d       = busy_q;
		write_mode_d = write_mode_q;
		addr_phase_d = addr_phase_q;
		bit_idx_d    = bit_idx_q;
		bytes_left_d = bytes_left_q;
		shift_d      = shift_q;
		cs_d         = cs_q;
		tx_src       = shift_q;
		result       = '0;
		result.mosi  = 1'b1;

		if (item.kind == KIND_START) begin
			if (!busy_q && item.length >= MIN_LENGTH) begin
				busy_d       = 1'b1;
				write_mode_d = item.is_write;
				addr_phase_d = 1'b1;
				bit_idx_d    = '0;
				bytes_left_d = item.length;
				shift_d      = item.is_write ? (item.address | WRITE_FLAG) : item.address;
				cs_d         = 1'b0;
			end
		end else if (busy_q) begin
			result.clock_pulse = 1'b1;
			bit_idx_d = bit_idx_q + BitIdxW'(1);
			if (addr_phase_q) begin
				result.mosi = shift_q[ByteW-1];
				shift_d     = {shift_q[ByteW-2:0], 1'b0};
				if (bit_idx_d == '0) begin
					addr_phase_d = 1'b0;
				end
			end else begin
				if (write_mode_q) begin
					// a fresh data byte is latched on the first tick of each byte
					if (bit_idx_q == '0) begin
						tx_src = item.write_byte;
					end
					result.mosi = tx_src[ByteW-1];
					shift_d     = {tx_src[ByteW-2:0], 1'b0};
				end else begin
					shift_d = {shift_q[ByteW-2:0], item.miso};
				end
				if (bit_idx_d == '0) begin
					result.byte_done = 1'b1;
					result.rx_byte   = write_mode_q ? '0 : shift_d;
					bytes_left_d     = bytes_left_q - ByteW'(1);
					if (bytes_left_d == '0) begin
						busy_d            = 1'b0;
						cs_d              = 1'b1;
						result.burst_last = 1'b1;
					end
				end
			end
		end
		result.chip_select_n = cs_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			write_mode_q <= 1'b0;
			addr_phase_q <= 1'b0;
			bit_idx_q    <= '0;
			bytes_left_q <= '0;
			shift_q      <= '0;
			cs_q         <= 1'b1;
		end else if (step) begin
			busy_q       <= busy_d;
			write_mode_q <= write_mode_d;
			addr_phase_q <= addr_phase_d;
			bit_idx_q    <= bit_idx_d;
			bytes_left_q <= bytes_left_d;
			shift_q      <= shift_d;
			cs_q         <= cs_d;
		end
	end

endmodule

FILE: rtl/spi_register_burst_master.sv
`timescale 1ns / 1ps

// channel | dir | handshake     | payload
// cmd     | in  | valid / ready | kind, address, is_write, length, write_byte, miso
// rsp     | out | valid / ready | chip_select_n, mosi, clock_pulse, byte_done,
//         |     |               | rx_byte, burst_last
//
// one item per cycle sustained while rsp is not stalled; a cmd item reaches rsp valid
// through the input register, then the burst state update into the result register
// every cmd item gives exactly one rsp item
// arst_n low: burst idle, chip select deselected, both stages empty
// a stall on rsp holds both stages; cmd ready stays high while a stage can move
module spi_register_burst_master (
	input logic      clk,
	input logic      arst_n,
	srbm_in_if.sink  cmd,
	srbm_out_if.source rsp
);
	import srbm_pkg::*;

	// input register stage
	logic      valid_s1;
	in_item_t  item_s1;
	// result register stage
	logic      valid_s2;
	out_item_t res_s2;

	logic      adv;
	out_item_t res_d;

	// stage 1 moves into stage 2 when the result register is free or draining
	assign adv       = valid_s1 && (!valid_s2 || rsp.ready);
	assign cmd.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			item_s1 <= '{kind: cmd.kind, address: cmd.address, is_write: cmd.is_write,
				length: cmd.length, write_byte: cmd.write_byte, miso: cmd.miso};
		end
	end

	// burst state machine, advanced once per item leaving stage 1
	srbm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.item   (item_s1),
		.result (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_d;
		end
	end

	assign rsp.valid         = valid_s2;
	assign rsp.chip_select_n = res_s2.chip_select_n;
	assign rsp.mosi          = res_s2.mosi;
	assign rsp.clock_pulse   = res_s2.clock_pulse;
	assign rsp.byte_done     = res_s2.byte_done;
	assign rsp.rx_byte       = res_s2.rx_byte;
	assign rsp.burst_last    = res_s2.burst_last;

endmodule
